/* hw/rtl/itrb_pkg.sv */
package itrb_pkg;

  localparam int unsigned CFG_W = 6;
  localparam logic [CFG_W-1:0] REG_COUNT_RESET = 6'd32;
  // a command read never returns more words than this
  localparam int unsigned CMD_READ_MAX = 8;

  typedef enum logic [2:0] {
    REQ_CLEAR     = 3'd0,
    REQ_SET_PTR   = 3'd1,
    REQ_WRITE     = 3'd2,
    REQ_READ_NEXT = 3'd3,
    REQ_READ_AT   = 3'd4,
    REQ_CMD_BYTE  = 3'd5,
    REQ_CMD_READ  = 3'd6,
    REQ_NONE      = 3'd7
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_num;
    logic [7:0] value;
    logic       last_byte;
    logic [7:0] cmd_length;
    logic       cmd_read;
  } req_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [7:0] byte_count;
    logic       last_out;
  } rsp_t;

endpackage

/* hw/rtl/itrb_stream_if.sv */
interface itrb_stream_if #(
  parameter type T = itrb_pkg::req_t
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/i2c_target_register_bank.sv */
// a target clear walks max(MAX_REGS, CMD_BUF_BYTES) entries of its rows, a command commit
// copies the n staged bytes into the command buffer, and a command read fetches its words in
// turn, each only once the last result word is loaded; one request at a time: the next request
// word is taken only after the last result is loaded into the output register; reset: a
// clearing pass over max(TARGETS*MAX_REGS, TARGETS*CMD_BUF_BYTES) addresses (4096 at the
// defaults) zeroes both stores with ready low; configuration taken throughout
module i2c_target_register_bank #(
  parameter int unsigned MAX_REGS      = 32,
  parameter int unsigned CMD_BUF_BYTES = 8,
  parameter int unsigned TARGETS       = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [itrb_pkg::CFG_W-1:0]  cfg_wdata_i,
  itrb_stream_if.sink                 req_i,
  itrb_stream_if.source               rsp_o
);
  import itrb_pkg::*;

  localparam int unsigned RF_DEPTH = TARGETS * MAX_REGS;
  localparam int unsigned CS_DEPTH = TARGETS * CMD_BUF_BYTES;
  localparam int unsigned RA_W     = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
  localparam int unsigned CA_W     = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1;
  localparam int unsigned TGT_W    = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int unsigned REG_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int unsigned SB_W     = (CMD_BUF_BYTES > 1) ? $clog2(CMD_BUF_BYTES) : 1;
  localparam int unsigned CLR_N    = (MAX_REGS > CMD_BUF_BYTES) ? MAX_REGS : CMD_BUF_BYTES;
  localparam int unsigned IDX_W    = $clog2(CLR_N + 1);
  localparam int unsigned INIT_N   = (RF_DEPTH > CS_DEPTH) ? RF_DEPTH : CS_DEPTH;
  localparam int unsigned INIT_W   = (INIT_N > 1) ? $clog2(INIT_N) : 1;

  localparam logic [8:0]        MAX_REGS_9     = 9'(MAX_REGS);
  localparam logic [8:0]        CMD_BUF_9      = 9'(CMD_BUF_BYTES);
  localparam logic [8:0]        CMD_READ_MAX_9 = 9'(CMD_READ_MAX);
  localparam logic [IDX_W-1:0]  CLR_LAST       = IDX_W'(CLR_N - 1);
  localparam logic [INIT_W-1:0] INIT_LAST      = INIT_W'(INIT_N - 1);
  localparam logic [INIT_W:0]   RF_DEPTH_I     = (INIT_W + 1)'(RF_DEPTH);
  localparam logic [INIT_W:0]   CS_DEPTH_I     = (INIT_W + 1)'(CS_DEPTH);

  typedef enum logic [9:0] {
    S_INIT     = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_DISP     = 10'b00_0000_0100,
    S_RDATA    = 10'b00_0000_1000,
    S_CLR      = 10'b00_0001_0000,
    S_CMT      = 10'b00_0010_0000,
    S_CMT_END  = 10'b00_0100_0000,
    S_CRD_RD   = 10'b00_1000_0000,
    S_CRD_DATA = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

  function automatic rsp_t mk_rsp(input logic [7:0] d, input status_e st,
                                  input logic [7:0] bc, input logic l);
    rsp_t r;
    r.data_out   = d;
    r.status     = st;
    r.byte_count = bc;
    r.last_out   = l;
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  reg_count_q;
  logic [REG_W-1:0]  ptr_q, ptr_d;
  logic [7:0]        staged_q, staged_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [INIT_W-1:0] init_q, init_d;
  logic              more_q, more_d;
  logic              rsp_valid_q, rsp_valid_d;

  req_kind_e         kind_q;
  logic [TGT_W-1:0]  dev_q;
  logic [7:0]        reg_q, val_q, len_q;
  logic              last_q;
  logic [7:0]        b0_q, b0_d, b1_q, b1_d;
  logic [IDX_W-1:0]  n_q, n_d;
  rsp_t              res_q, res_d;
  rsp_t              rsp_data_q;

  logic [TGT_W-1:0]  dev_mod [128];
  logic              accept, rsp_free, rsp_load;
  logic [8:0]        cnt9, ptr_inc9;
  logic              reg_ok, b0_ok, len_bad, too_long, crd_last;
  logic [7:0]        staged_inc;
  logic [RA_W-1:0]   rf_row;
  logic [CA_W-1:0]   cs_row;
  req_kind_e         kind_in;

  logic              rf_we, rf_re, cs_we, cs_re, sb_we, sb_re;
  logic [RA_W-1:0]   rf_waddr, rf_raddr;
  logic [CA_W-1:0]   cs_waddr, cs_raddr;
  logic [SB_W-1:0]   sb_waddr, sb_raddr;
  logic [7:0]        rf_wdata, rf_rdata, cs_wdata, cs_rdata, sb_wdata, sb_rdata;

  // target address folded into the populated range
  for (genvar g = 0; g < 128; g++) begin : g_dev_mod
    assign dev_mod[g] = TGT_W'(g % TARGETS);
  end

  itrb_ram #(.WIDTH(8), .DEPTH(RF_DEPTH)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (rf_re),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  itrb_ram #(.WIDTH(8), .DEPTH(CS_DEPTH)) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (cs_waddr),
    .wdata_i (cs_wdata),
    .re_i    (cs_re),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  itrb_ram #(.WIDTH(8), .DEPTH(CMD_BUF_BYTES)) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (sb_waddr),
    .wdata_i (sb_wdata),
    .re_i    (sb_re),
    .raddr_i (sb_raddr),
    .rdata_o (sb_rdata)
  );

  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_free      = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_data_q;

  // zero acts as one, anything above the store width is clamped
  assign cnt9 = (reg_count_q == '0) ? 9'd1 :
                ((9'(reg_count_q) > MAX_REGS_9) ? MAX_REGS_9 : 9'(reg_count_q));

  assign reg_ok     = {1'b0, reg_q} < cnt9;
  assign b0_ok      = {1'b0, b0_q} < cnt9;
  assign ptr_inc9   = 9'(ptr_q) + 9'd1;
  assign staged_inc = (staged_q == 8'hFF) ? staged_q : staged_q + 8'd1;
  assign too_long   = {1'b0, staged_inc} > CMD_BUF_9;
  assign len_bad    = ({1'b0, len_q} > CMD_BUF_9) || ({1'b0, len_q} > CMD_READ_MAX_9);
  assign crd_last   = (9'(idx_q) + 9'd1) == {1'b0, len_q};
  assign rf_row     = RA_W'(dev_q) * RA_W'(MAX_REGS);
  assign cs_row     = CA_W'(dev_q) * CA_W'(CMD_BUF_BYTES);

  always_comb begin
    kind_in = req_kind_e'(req_i.payload.req_type);
    if (kind_in == REQ_CMD_BYTE && req_i.payload.cmd_read) begin
      kind_in = REQ_CMD_READ;
    end
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    staged_d    = staged_q;
    idx_d       = idx_q;
    init_d      = init_q;
    more_d      = more_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    n_d         = n_q;
    res_d       = res_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_load    = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = '0;
    rf_wdata    = '0;
    rf_re       = 1'b0;
    rf_raddr    = '0;
    cs_we       = 1'b0;
    cs_waddr    = '0;
    cs_wdata    = '0;
    cs_re       = 1'b0;
    cs_raddr    = '0;
    sb_we       = 1'b0;
    sb_waddr    = '0;
    sb_wdata    = '0;
    sb_re       = 1'b0;
    sb_raddr    = '0;

    case (state_q)
      S_INIT: begin
        rf_we    = {1'b0, init_q} < RF_DEPTH_I;
        rf_waddr = RA_W'(init_q);
        cs_we    = {1'b0, init_q} < CS_DEPTH_I;
        cs_waddr = CA_W'(init_q);
        if (init_q == INIT_LAST) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + INIT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        more_d = 1'b0;
        case (kind_q)
          REQ_CLEAR: begin
            idx_d   = '0;
            state_d = S_CLR;
          end
          REQ_SET_PTR: begin
            if (reg_ok) begin
              ptr_d = REG_W'(reg_q);
              res_d = mk_rsp(8'h00, ST_OK, 8'h00, 1'b1);
            end else begin
              res_d = mk_rsp(8'h00, ST_RANGE, 8'h00, 1'b1);
            end
            state_d = S_RESP;
          end
          REQ_WRITE: begin
            if (reg_ok) begin
              ptr_d    = REG_W'(reg_q);
              rf_we    = 1'b1;
              rf_waddr = rf_row + RA_W'(reg_q);
              rf_wdata = val_q;
              res_d    = mk_rsp(8'h00, ST_OK, 8'h00, 1'b1);
            end else begin
              res_d = mk_rsp(8'h00, ST_RANGE, 8'h00, 1'b1);
            end
            state_d = S_RESP;
          end
          REQ_READ_NEXT: begin
            rf_re    = 1'b1;
            rf_raddr = rf_row + RA_W'(ptr_q);
            ptr_d    = (ptr_inc9 >= cnt9) ? '0 : REG_W'(ptr_inc9);
            state_d  = S_RDATA;
          end
          REQ_READ_AT: begin
            if (reg_ok) begin
              ptr_d    = REG_W'(reg_q);
              rf_re    = 1'b1;
              rf_raddr = rf_row + RA_W'(reg_q);
              state_d  = S_RDATA;
            end else begin
              res_d   = mk_rsp(8'h00, ST_RANGE, 8'h00, 1'b1);
              state_d = S_RESP;
            end
          end
          REQ_CMD_BYTE: begin
            if ({1'b0, staged_q} < CMD_BUF_9) begin
              sb_we    = 1'b1;
              sb_waddr = SB_W'(staged_q);
              sb_wdata = val_q;
            end
            staged_d = staged_inc;
            if (!last_q) begin
              res_d   = mk_rsp(8'h00, ST_OK, staged_inc, 1'b0);
              state_d = S_RESP;
            end else begin
              staged_d = '0;
              if (too_long) begin
                res_d   = mk_rsp(8'h00, ST_TOO_LONG, 8'h00, 1'b1);
                state_d = S_RESP;
              end else begin
                n_d     = IDX_W'(staged_inc);
                idx_d   = '0;
                state_d = S_CMT;
              end
            end
          end
          REQ_CMD_READ: begin
            if (len_bad) begin
              res_d   = mk_rsp(8'h00, ST_TOO_LONG, 8'h00, 1'b1);
              state_d = S_RESP;
            end else if (len_q == '0) begin
              res_d   = mk_rsp(8'h00, ST_OK, 8'h00, 1'b1);
              state_d = S_RESP;
            end else begin
              idx_d   = '0;
              state_d = S_CRD_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RDATA: begin
        res_d   = mk_rsp(rf_rdata, ST_OK, 8'h00, 1'b1);
        state_d = S_RESP;
      end
      S_CLR: begin
        rf_we    = idx_q < IDX_W'(MAX_REGS);
        rf_waddr = rf_row + RA_W'(idx_q);
        cs_we    = idx_q < IDX_W'(CMD_BUF_BYTES);
        cs_waddr = cs_row + CA_W'(idx_q);
        if (idx_q == CLR_LAST) begin
          res_d   = mk_rsp(8'h00, ST_OK, 8'h00, 1'b1);
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_CMT: begin
        // staging read runs one word ahead of the command buffer write
        if (idx_q < n_q) begin
          sb_re    = 1'b1;
          sb_raddr = SB_W'(idx_q);
        end
        if (idx_q != '0) begin
          cs_we    = 1'b1;
          cs_waddr = cs_row + CA_W'(idx_q - IDX_W'(1));
          cs_wdata = sb_rdata;
        end
        if (idx_q == IDX_W'(1)) begin
          b0_d = sb_rdata;
        end
        if (idx_q == IDX_W'(2)) begin
          b1_d = sb_rdata;
        end
        if (idx_q == n_q) begin
          state_d = S_CMT_END;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_CMT_END: begin
        // one-word command sets the pointer, two-word command writes a register
        if ((n_q == IDX_W'(1) || n_q == IDX_W'(2)) && b0_ok) begin
          ptr_d = REG_W'(b0_q);
        end
        if (n_q == IDX_W'(2) && b0_ok) begin
          rf_we    = 1'b1;
          rf_waddr = rf_row + RA_W'(b0_q);
          rf_wdata = b1_q;
        end
        res_d   = mk_rsp(8'h00, ST_OK, 8'(n_q), 1'b1);
        state_d = S_RESP;
      end
      S_CRD_RD: begin
        cs_re    = 1'b1;
        cs_raddr = cs_row + CA_W'(idx_q);
        state_d  = S_CRD_DATA;
      end
      S_CRD_DATA: begin
        res_d   = mk_rsp(cs_rdata, ST_OK, len_q, crd_last);
        more_d  = !crd_last;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_free) begin
          rsp_load    = 1'b1;
          rsp_valid_d = 1'b1;
          if (more_q) begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_CRD_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      reg_count_q <= REG_COUNT_RESET;
      ptr_q       <= '0;
      staged_q    <= '0;
      idx_q       <= '0;
      init_q      <= '0;
      more_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      staged_q    <= staged_d;
      idx_q       <= idx_d;
      init_q      <= init_d;
      more_q      <= more_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        reg_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_in;
      dev_q  <= dev_mod[req_i.payload.dev_addr];
      reg_q  <= req_i.payload.reg_num;
      val_q  <= req_i.payload.value;
      last_q <= req_i.payload.last_byte;
      len_q  <= req_i.payload.cmd_length;
    end
    b0_q  <= b0_d;
    b1_q  <= b1_d;
    n_q   <= n_d;
    res_q <= res_d;
    if (rsp_load) begin
      rsp_data_q <= res_q;
    end
  end

  a_load_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> rsp_free)
    else $error("result word loaded over one not yet taken");

  a_reg_ram_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> !rf_re)
    else $error("register store read and written in one cycle");

  a_staging_emptied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP && kind_q == REQ_CMD_BYTE && last_q) |=> staged_q == '0)
    else $error("staging count not emptied after final command byte");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |=> 9'(ptr_q) < MAX_REGS_9)
    else $error("register pointer beyond store width");

endmodule

/* hw/rtl/itrb_ram.sv */
module itrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
